// ----- hdl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Arena geometry, header layout, status codes and the controller to datapath
// command and status types.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 48;
  localparam int GRANULES     = ARENA_BYTES / ALIGN_BYTES;
  localparam int GRAN_W       = $clog2(GRANULES);
  localparam int ALIGN_W      = $clog2(ALIGN_BYTES);
  localparam int OFF_W        = $clog2(ARENA_BYTES) + 2;
  localparam int SIZE_W       = $clog2(ARENA_BYTES) + 1;

  localparam int THR_W     = 17;
  localparam int MSPL_W    = 11;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;
  localparam int REQ_W     = 16;
  localparam int ADDR_W    = 16;
  localparam int STATUS_W  = 3;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(32768);
  localparam logic [MSPL_W-1:0] MSPL_RESET = MSPL_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_DED_THR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEDICATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREE_IGN  = 3'd4;

  typedef struct packed {
    logic              valid;
    logic              free;
    logic [SIZE_W-1:0] size;
    logic [GRAN_W-1:0] prev;
  } hdr_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_RD_H,
    OP_SCAN_NEXT,
    OP_TAKE_A,
    OP_RD_N,
    OP_W_BI_NOSPL,
    OP_W_SPLIT,
    OP_W_ON,
    OP_W_BI_SPL,
    OP_TAKE_F,
    OP_ABSORB,
    OP_W_NPREV,
    OP_W_CUR,
    OP_RD_PV,
    OP_TAKE_P
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic                res_we;
    logic [STATUS_W-1:0] res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free_cmd;
    logic req_zero;
    logic free_bad;
    logic scan_end;
    logic fit;
    logic dedicated;
    logic split;
    logic n_beyond;
    logic rd_valid;
    logic rd_free;
    logic absorbed;
    logic pv_zero;
  } dp_flags_t;

endpackage

// ----- hdl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Manages a 64 KiB arena as address-ordered blocks with 48-byte headers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   command_i, request_size_i,
//                                             payload_address_i
// result    out        done_o, one cycle      status_o, granted_address_o,
//                                             granted_size_o
// config    in         cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// An allocate walks the block headers in address order, reading and checking
// each in turn; a split adds writes of the new free block, of the block after
// it and of the granted block. A zero size is refused without a walk. The walk
// is set by the single-port header store. A free merges in each free block that
// follows and a free previous block. After reset the header store is cleared
// with busy held high. Each transaction gives one result on done_o in the
// first cycle in which busy is low again; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command_i,
  input  logic [ffha_pkg::REQ_W-1:0]     request_size_i,
  input  logic [ffha_pkg::ADDR_W-1:0]    payload_address_i,
  input  logic                           cfg_we_i,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [ffha_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output logic [ffha_pkg::STATUS_W-1:0]  status_o,
  output logic [ffha_pkg::ADDR_W-1:0]    granted_address_o,
  output logic [ffha_pkg::ADDR_W-1:0]    granted_size_o
);

  ffha_pkg::dp_cmd_t   cmd;
  ffha_pkg::dp_flags_t flags;

  ffha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .flags_i (flags),
    .cmd_o   (cmd)
  );

  ffha_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .flags_o           (flags),
    .command_i         (command_i),
    .request_size_i    (request_size_i),
    .payload_address_i (payload_address_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .granted_size_o    (granted_size_o)
  );

endmodule

// ----- hdl/ffha_datapath.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator datapath
// Header store, working registers, configuration registers and result register.
// ----------------------------------------------------------------------------
module ffha_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ffha_pkg::dp_cmd_t              cmd_i,
  output ffha_pkg::dp_flags_t            flags_o,
  input  logic                           command_i,
  input  logic [ffha_pkg::REQ_W-1:0]     request_size_i,
  input  logic [ffha_pkg::ADDR_W-1:0]    payload_address_i,
  input  logic                           cfg_we_i,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [ffha_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output logic [ffha_pkg::STATUS_W-1:0]  status_o,
  output logic [ffha_pkg::ADDR_W-1:0]    granted_address_o,
  output logic [ffha_pkg::ADDR_W-1:0]    granted_size_o
);

  localparam int OFF_W  = ffha_pkg::OFF_W;
  localparam int SIZE_W = ffha_pkg::SIZE_W;
  localparam int GRAN_W = ffha_pkg::GRAN_W;
  localparam int ALIGN_W = ffha_pkg::ALIGN_W;
  localparam logic [OFF_W-1:0] HDR_OFF   = OFF_W'(ffha_pkg::HEADER_BYTES);
  localparam logic [OFF_W-1:0] ARENA_OFF = OFF_W'(ffha_pkg::ARENA_BYTES);
  localparam logic [GRAN_W-1:0] FIRST_IDX =
    GRAN_W'(ffha_pkg::HEADER_BYTES / ffha_pkg::ALIGN_BYTES);

  ffha_pkg::hdr_t mem [ffha_pkg::GRANULES];
  ffha_pkg::hdr_t rdata_q, cur_q, on_hdr_q, wdata, init_hdr;
  logic mem_we, mem_re;
  logic [GRAN_W-1:0] waddr, raddr, clr_q;
  logic [OFF_W-1:0] h_q, n_off, s_off;
  logic [SIZE_W-1:0] size_q, rem;
  logic [ffha_pkg::ADDR_W-1:0] p_q;
  logic is_free_q, req_zero_q, absorbed_q, on_ok_q;
  logic [ffha_pkg::THR_W-1:0] thr_q;
  logic [ffha_pkg::MSPL_W-1:0] mspl_q;
  logic valid_q, ok_alloc;
  logic [ffha_pkg::STATUS_W-1:0] status_q;
  logic [ffha_pkg::ADDR_W-1:0] gaddr_q, gsize_q;

  assign n_off = h_q + HDR_OFF + OFF_W'(cur_q.size);
  assign s_off = h_q + HDR_OFF + OFF_W'(size_q);
  assign rem   = cur_q.size - size_q;

  always_comb begin
    init_hdr       = '0;
    init_hdr.valid = 1'b1;
    init_hdr.free  = 1'b1;
    init_hdr.size  = SIZE_W'(ffha_pkg::ARENA_BYTES - 2 * ffha_pkg::HEADER_BYTES);
  end

  // Status back to the controller.
  always_comb begin
    flags_o.clr_last    = (clr_q == GRAN_W'(ffha_pkg::GRANULES - 1));
    flags_o.is_free_cmd = is_free_q;
    flags_o.req_zero    = req_zero_q;
    flags_o.free_bad    = (p_q < ffha_pkg::ADDR_W'(2 * ffha_pkg::HEADER_BYTES)) ||
                          (p_q[ALIGN_W-1:0] != '0);
    flags_o.scan_end    = (h_q >= ARENA_OFF) || !rdata_q.valid;
    flags_o.fit         = rdata_q.free && (rdata_q.size >= size_q);
    flags_o.dedicated   = (size_q >= thr_q);
    flags_o.split       = (rem >= (SIZE_W'(ffha_pkg::HEADER_BYTES) + SIZE_W'(mspl_q)));
    flags_o.n_beyond    = (n_off >= ARENA_OFF);
    flags_o.rd_valid    = rdata_q.valid;
    flags_o.rd_free     = rdata_q.free;
    flags_o.absorbed    = absorbed_q;
    flags_o.pv_zero     = (cur_q.prev == '0);
  end

  // Memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = h_q[ALIGN_W +: GRAN_W];
    raddr  = h_q[ALIGN_W +: GRAN_W];
    wdata  = cur_q;
    case (cmd_i.op)
      ffha_pkg::OP_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = (clr_q == FIRST_IDX) ? init_hdr : '0;
      end
      ffha_pkg::OP_RD_H: begin
        mem_re = 1'b1;
      end
      ffha_pkg::OP_RD_N: begin
        mem_re = 1'b1;
        raddr  = n_off[ALIGN_W +: GRAN_W];
      end
      ffha_pkg::OP_RD_PV: begin
        mem_re = 1'b1;
        raddr  = cur_q.prev;
      end
      ffha_pkg::OP_W_BI_NOSPL: begin
        mem_we     = 1'b1;
        wdata.free = 1'b0;
      end
      ffha_pkg::OP_W_SPLIT: begin
        mem_we     = 1'b1;
        waddr      = s_off[ALIGN_W +: GRAN_W];
        wdata.valid = 1'b1;
        wdata.free = 1'b1;
        wdata.size = rem - SIZE_W'(ffha_pkg::HEADER_BYTES);
        wdata.prev = h_q[ALIGN_W +: GRAN_W];
      end
      ffha_pkg::OP_W_ON: begin
        mem_we     = on_ok_q;
        waddr      = n_off[ALIGN_W +: GRAN_W];
        wdata      = on_hdr_q;
        wdata.prev = s_off[ALIGN_W +: GRAN_W];
      end
      ffha_pkg::OP_W_BI_SPL: begin
        mem_we     = 1'b1;
        wdata.free = 1'b0;
        wdata.size = size_q;
      end
      ffha_pkg::OP_ABSORB: begin
        mem_we = 1'b1;
        waddr  = n_off[ALIGN_W +: GRAN_W];
        wdata  = '0;
      end
      ffha_pkg::OP_W_NPREV: begin
        mem_we     = 1'b1;
        waddr      = n_off[ALIGN_W +: GRAN_W];
        wdata      = rdata_q;
        wdata.prev = h_q[ALIGN_W +: GRAN_W];
      end
      ffha_pkg::OP_W_CUR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      absorbed_q <= 1'b0;
      on_ok_q    <= 1'b0;
      is_free_q  <= 1'b0;
      req_zero_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        ffha_pkg::OP_CLR: begin
          clr_q <= clr_q + 1'b1;
        end
        ffha_pkg::OP_LOAD: begin
          is_free_q  <= (command_i == ffha_pkg::CMD_FREE);
          req_zero_q <= (request_size_i == '0);
          p_q        <= payload_address_i;
          size_q     <= (SIZE_W'(request_size_i) + SIZE_W'(ffha_pkg::ALIGN_BYTES - 1)) &
                        ~SIZE_W'(ffha_pkg::ALIGN_BYTES - 1);
          h_q        <= (command_i == ffha_pkg::CMD_FREE) ?
                        (OFF_W'(payload_address_i) - HDR_OFF) : HDR_OFF;
        end
        ffha_pkg::OP_SCAN_NEXT: begin
          h_q <= h_q + HDR_OFF + OFF_W'(rdata_q.size);
        end
        ffha_pkg::OP_TAKE_A: begin
          cur_q <= rdata_q;
        end
        ffha_pkg::OP_W_SPLIT: begin
          on_ok_q  <= (n_off < ARENA_OFF) && rdata_q.valid;
          on_hdr_q <= rdata_q;
        end
        ffha_pkg::OP_W_BI_SPL: begin
          cur_q.size <= size_q;
        end
        ffha_pkg::OP_TAKE_F: begin
          cur_q      <= '{valid: rdata_q.valid, free: 1'b1, size: rdata_q.size,
                          prev: rdata_q.prev};
          absorbed_q <= 1'b0;
        end
        ffha_pkg::OP_ABSORB: begin
          cur_q.size <= cur_q.size + SIZE_W'(ffha_pkg::HEADER_BYTES) + rdata_q.size;
          absorbed_q <= 1'b1;
        end
        ffha_pkg::OP_TAKE_P: begin
          cur_q      <= rdata_q;
          h_q        <= {{(OFF_W - GRAN_W - ALIGN_W){1'b0}}, cur_q.prev, {ALIGN_W{1'b0}}};
          absorbed_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ffha_pkg::THR_RESET;
      mspl_q <= ffha_pkg::MSPL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ffha_pkg::CFG_DED_THR:   thr_q  <= cfg_wdata_i[ffha_pkg::THR_W-1:0];
        ffha_pkg::CFG_MIN_SPLIT: mspl_q <= cfg_wdata_i[ffha_pkg::MSPL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result register; a grant reports the block's payload offset and size.
  assign ok_alloc = (cmd_i.res_code == ffha_pkg::ST_DONE) && !is_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.res_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      status_q <= cmd_i.res_code;
      gaddr_q  <= ok_alloc ? ffha_pkg::ADDR_W'(h_q + HDR_OFF) : '0;
      gsize_q  <= ok_alloc ? cur_q.size[ffha_pkg::ADDR_W-1:0] : '0;
    end
  end

  assign done_o            = valid_q;
  assign status_o          = status_q;
  assign granted_address_o = gaddr_q;
  assign granted_size_o    = gsize_q;

  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re) else $error("header store read and written in one cycle");
  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != ffha_pkg::ST_DONE) |-> (gaddr_q == '0 && gsize_q == '0))
    else $error("refused transaction carries a grant");
  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (gsize_q[ALIGN_W-1:0] == '0 && gaddr_q[ALIGN_W-1:0] == '0))
    else $error("grant not aligned");

endmodule

// ----- hdl/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator controller
// Sequences store clearing, the first-fit walk, splitting and coalescing.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ffha_pkg::dp_flags_t flags_i,
  output ffha_pkg::dp_cmd_t   cmd_o
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_A_RD  = 5'd3;
  localparam logic [4:0] S_A_CHK = 5'd4;
  localparam logic [4:0] S_A_SPL = 5'd5;
  localparam logic [4:0] S_A_SPW = 5'd6;
  localparam logic [4:0] S_A_ONW = 5'd7;
  localparam logic [4:0] S_A_BIW = 5'd8;
  localparam logic [4:0] S_F_RD  = 5'd9;
  localparam logic [4:0] S_F_CHK = 5'd10;
  localparam logic [4:0] S_M_RD  = 5'd11;
  localparam logic [4:0] S_M_CHK = 5'd12;
  localparam logic [4:0] S_M_END = 5'd13;
  localparam logic [4:0] S_P_RD  = 5'd14;
  localparam logic [4:0] S_P_CHK = 5'd15;
  localparam logic [4:0] S_RES   = 5'd16;

  logic [4:0] state_q, state_d;
  logic [ffha_pkg::STATUS_W-1:0] code_q, code_d;
  logic phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    phase_d = phase_q;
    cmd_o   = '{op: ffha_pkg::OP_NONE, res_we: 1'b0, res_code: code_q};
    case (state_q)
      S_CLR: begin
        cmd_o.op = ffha_pkg::OP_CLR;
        if (flags_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = ffha_pkg::OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        phase_d = 1'b0;
        if (flags_i.is_free_cmd) begin
          if (flags_i.free_bad) begin
            code_d  = ffha_pkg::ST_FREE_IGN;
            state_d = S_RES;
          end else begin
            state_d = S_F_RD;
          end
        end else if (flags_i.req_zero) begin
          code_d  = ffha_pkg::ST_ZERO_SIZE;
          state_d = S_RES;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd_o.op = ffha_pkg::OP_RD_H;
        state_d  = S_A_CHK;
      end
      S_A_CHK: begin
        if (flags_i.scan_end) begin
          code_d  = flags_i.dedicated ? ffha_pkg::ST_DEDICATED : ffha_pkg::ST_NO_SPACE;
          state_d = S_RES;
        end else if (flags_i.fit) begin
          cmd_o.op = ffha_pkg::OP_TAKE_A;
          state_d  = S_A_SPL;
        end else begin
          cmd_o.op = ffha_pkg::OP_SCAN_NEXT;
          state_d  = S_A_RD;
        end
      end
      S_A_SPL: begin
        code_d = ffha_pkg::ST_DONE;
        if (flags_i.split) begin
          cmd_o.op = ffha_pkg::OP_RD_N;
          state_d  = S_A_SPW;
        end else begin
          cmd_o.op = ffha_pkg::OP_W_BI_NOSPL;
          state_d  = S_RES;
        end
      end
      S_A_SPW: begin
        cmd_o.op = ffha_pkg::OP_W_SPLIT;
        state_d  = S_A_ONW;
      end
      S_A_ONW: begin
        cmd_o.op = ffha_pkg::OP_W_ON;
        state_d  = S_A_BIW;
      end
      S_A_BIW: begin
        cmd_o.op = ffha_pkg::OP_W_BI_SPL;
        state_d  = S_RES;
      end
      S_F_RD: begin
        cmd_o.op = ffha_pkg::OP_RD_H;
        state_d  = S_F_CHK;
      end
      S_F_CHK: begin
        if (!flags_i.rd_valid || flags_i.rd_free) begin
          code_d  = ffha_pkg::ST_FREE_IGN;
          state_d = S_RES;
        end else begin
          cmd_o.op = ffha_pkg::OP_TAKE_F;
          code_d   = ffha_pkg::ST_DONE;
          state_d  = S_M_RD;
        end
      end
      S_M_RD: begin
        if (flags_i.n_beyond) begin
          state_d = S_M_END;
        end else begin
          cmd_o.op = ffha_pkg::OP_RD_N;
          state_d  = S_M_CHK;
        end
      end
      S_M_CHK: begin
        if (flags_i.rd_valid && flags_i.rd_free) begin
          cmd_o.op = ffha_pkg::OP_ABSORB;
          state_d  = S_M_RD;
        end else begin
          // The block that now follows the merged one points back at it.
          if (flags_i.rd_valid && flags_i.absorbed) cmd_o.op = ffha_pkg::OP_W_NPREV;
          state_d = S_M_END;
        end
      end
      S_M_END: begin
        cmd_o.op = ffha_pkg::OP_W_CUR;
        if (!phase_q && !flags_i.pv_zero) state_d = S_P_RD;
        else                              state_d = S_RES;
      end
      S_P_RD: begin
        cmd_o.op = ffha_pkg::OP_RD_PV;
        state_d  = S_P_CHK;
      end
      S_P_CHK: begin
        if (flags_i.rd_valid && flags_i.rd_free) begin
          cmd_o.op = ffha_pkg::OP_TAKE_P;
          phase_d  = 1'b1;
          state_d  = S_M_RD;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        cmd_o.res_we = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      code_q  <= ffha_pkg::ST_DONE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      phase_q <= phase_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction did not start work");
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES) |=> (state_q == S_IDLE)) else $error("result step not followed by idle");

endmodule
